FILE: hw/rtl/midi_tempo_event_extractor_top_macros.svh
// ----------------------------------------------------------------------------
// midi_tempo_event_extractor_top_macros
// Assertion macros shared by the tempo extractor RTL.
// ----------------------------------------------------------------------------
// Define ASSERT_OFF to compile every check away.
`ifndef MIDI_TEMPO_EVENT_EXTRACTOR_TOP_MACROS_SVH
`define MIDI_TEMPO_EVENT_EXTRACTOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define MTE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mte assertion failed");
// Condition must never be seen outside reset.
`define MTE_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mte forbidden condition seen");
`else
`define MTE_ASSERT(label, prop)
`define MTE_ASSERT_NEVER(label, cond)
`endif
`endif

FILE: hw/rtl/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Types and constants of the MIDI set-tempo event extractor.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int unsigned HdrLen   = 14;
  localparam int unsigned TagLen   = 4;
  localparam int unsigned ChunkLen = 8;

  localparam logic [7:0] StatusMeta  = 8'hFF;
  localparam logic [7:0] StatusSysex = 8'hF0;
  localparam logic [7:0] StatusEscape = 8'hF7;
  localparam logic [7:0] MetaTempo   = 8'h51;
  localparam logic [7:0] MetaEot     = 8'h2F;
  localparam logic [31:0] TempoLen   = 32'd3;

  // Channel message status nibbles.
  localparam logic [3:0] ChanNoteOff   = 4'h8;
  localparam logic [3:0] ChanNoteOn    = 4'h9;
  localparam logic [3:0] ChanPolyPress = 4'hA;
  localparam logic [3:0] ChanControl   = 4'hB;
  localparam logic [3:0] ChanProgram   = 4'hC;
  localparam logic [3:0] ChanPressure  = 4'hD;
  localparam logic [3:0] ChanPitch     = 4'hE;

  // "MTrk"
  localparam logic [7:0] TagBytes [TagLen] = '{8'h4D, 8'h54, 8'h72, 8'h6B};

  typedef enum logic [10:0] {
    PH_HEADER  = 11'b000_0000_0001,
    PH_CHUNK   = 11'b000_0000_0010,
    PH_DELTA   = 11'b000_0000_0100,
    PH_STATUS  = 11'b000_0000_1000,
    PH_MTYPE   = 11'b000_0001_0000,
    PH_MLEN    = 11'b000_0010_0000,
    PH_TEMPO   = 11'b000_0100_0000,
    PH_SKIP    = 11'b000_1000_0000,
    PH_SXLEN   = 11'b001_0000_0000,
    PH_ABANDON = 11'b010_0000_0000,
    PH_DONE    = 11'b100_0000_0000
  } mte_phase_e;

  typedef enum logic [1:0] {
    KIND_TEMPO     = 2'd0,
    KIND_END_CLEAN = 2'd1,
    KIND_END_TRUNC = 2'd2
  } mte_kind_e;

  typedef struct packed {
    mte_kind_e   kind;
    logic [15:0] track;
    logic [31:0] tick;
    logic [23:0] tempo;
    logic        last;
  } mte_result_t;

  // Results produced by one byte, oldest in slot 0.
  typedef struct packed {
    logic [1:0]          cnt;
    mte_result_t [1:0]   res;
  } mte_push_t;

endpackage

FILE: hw/rtl/midi_tempo_event_extractor_top.sv
// ----------------------------------------------------------------------------
// midi_tempo_event_extractor_top
// Streaming set-tempo event extractor for Standard MIDI Files.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one file byte per transaction (file_byte_i) with
//   end_of_file_i marking the last byte. A transaction completes on a clock
//   edge with in_valid_i high and in_stall_o low.
//   Output channel: one result per transaction, same valid/stall rule.
//   A set-tempo meta with a nonzero tempo yields a tempo result on its
//   third data byte; the last byte of the file adds an end result (clean
//   or truncated track), after which the parser is back in its reset state
//   for the next file. A result passes the input register, then the parser
//   step into the result queue, before it is offered.
//   Throughput: one byte per cycle while the queue has room; the parser
//   step is combinational. Only a final byte can yield two results.
//   Stall: when the receiver stalls, results collect in a four-entry queue;
//   the input register holds its byte once the queue lacks room for two
//   results, and in_stall_o rises until space frees up.
//   Reset: rst_ni clears the parser state, input register and queue.
// ----------------------------------------------------------------------------
module midi_tempo_event_extractor_top import mte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [15:0] track_number_o,
  output logic [31:0] event_tick_o,
  output logic [23:0] tempo_us_o,
  output logic        last_result_o
);

  logic        stage_valid_q, stage_valid_d;
  logic [7:0]  stage_byte_q;
  logic        stage_eof_q;
  logic        room;
  logic        advance;
  logic        accept;
  mte_push_t   push;
  mte_result_t out_res;

  // Advance the held byte into the parser only when the queue can take both
  // possible results; hold it otherwise.
  assign advance    = stage_valid_q && room;
  assign in_stall_o = stage_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (advance) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  // Input payload register, loaded on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_byte_q <= file_byte_i;
      stage_eof_q  <= end_of_file_i;
    end
  end

  mte_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (advance),
    .file_byte_i   (stage_byte_q),
    .end_of_file_i (stage_eof_q),
    .push_o        (push)
  );

  mte_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  // Drive the result fields straight from the queue head.
  assign result_kind_o  = out_res.kind;
  assign track_number_o = out_res.track;
  assign event_tick_o   = out_res.tick;
  assign tempo_us_o     = out_res.tempo;
  assign last_result_o  = out_res.last;

endmodule

FILE: hw/rtl/mte_parser.sv
// ----------------------------------------------------------------------------
// mte_parser
// Byte-wise file parser: state registers plus the combinational step logic.
// ----------------------------------------------------------------------------
`include "midi_tempo_event_extractor_top_macros.svh"

module mte_parser import mte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       go_i,
  input  logic [7:0] file_byte_i,
  input  logic       end_of_file_i,
  output mte_push_t  push_o
);

  mte_phase_e  phase_q, phase_d;
  logic [3:0]  hdr_seen_q, hdr_seen_d;
  logic [2:0]  chunk_idx_q, chunk_idx_d;
  logic        tag_ok_q, tag_ok_d;
  logic [31:0] trk_left_q, trk_left_d;
  logic [31:0] tick_q, tick_d;
  logic [7:0]  rs_q, rs_d;
  logic        rs_vld_q, rs_vld_d;
  logic [15:0] track_q, track_d;
  logic [31:0] vacc_q, vacc_d;
  logic [7:0]  meta_q, meta_d;
  logic [31:0] skip_q, skip_d;
  logic [23:0] tacc_q, tacc_d;
  logic [1:0]  tseen_q, tseen_d;

  logic [31:0] vacc_sh;
  logic [7:0]  st;
  logic        st_explicit;
  logic        skip_req;
  logic [31:0] skip_len;
  logic        in_track;
  logic        truncated;
  mte_result_t tempo_res;
  mte_result_t end_res;
  logic        have_tempo;

  assign vacc_sh = {vacc_q[24:0], file_byte_i[6:0]};

  always_comb begin
    phase_d     = phase_q;
    hdr_seen_d  = hdr_seen_q;
    chunk_idx_d = chunk_idx_q;
    tag_ok_d    = tag_ok_q;
    trk_left_d  = trk_left_q;
    tick_d      = tick_q;
    rs_d        = rs_q;
    rs_vld_d    = rs_vld_q;
    track_d     = track_q;
    vacc_d      = vacc_q;
    meta_d      = meta_q;
    skip_d      = skip_q;
    tacc_d      = tacc_q;
    tseen_d     = tseen_q;
    skip_req    = 1'b0;
    skip_len    = '0;
    have_tempo  = 1'b0;
    st          = file_byte_i[7] ? file_byte_i : rs_q;
    st_explicit = file_byte_i[7];
    in_track    = phase_q inside {PH_DELTA, PH_STATUS, PH_MTYPE, PH_MLEN, PH_TEMPO,
                                  PH_SKIP, PH_SXLEN, PH_ABANDON};

    case (phase_q)
      PH_HEADER: begin
        hdr_seen_d = hdr_seen_q + 4'd1;
        if (hdr_seen_d >= 4'(HdrLen)) begin
          phase_d     = PH_CHUNK;
          chunk_idx_d = '0;
          tag_ok_d    = 1'b1;
        end
      end
      PH_CHUNK: begin
        if (!chunk_idx_q[2]) begin
          if (file_byte_i != TagBytes[chunk_idx_q[1:0]]) tag_ok_d = 1'b0;
        end else begin
          trk_left_d = {trk_left_q[23:0], file_byte_i};
        end
        if (chunk_idx_q == 3'(ChunkLen - 1)) begin
          chunk_idx_d = '0;
          if (!tag_ok_d) begin
            phase_d = PH_DONE;
          end else if (trk_left_d == '0) begin
            if (track_q != '1) track_d = track_q + 16'd1;
            tag_ok_d = 1'b1;
          end else begin
            tick_d   = '0;
            rs_vld_d = 1'b0;
            rs_d     = '0;
            phase_d  = PH_DELTA;
            vacc_d   = '0;
          end
        end else begin
          chunk_idx_d = chunk_idx_q + 3'd1;
        end
        if (chunk_idx_d == '0 && phase_d == PH_CHUNK) trk_left_d = '0;
      end
      PH_DELTA: begin
        vacc_d = vacc_sh;
        if (!file_byte_i[7]) begin
          tick_d  = tick_q + vacc_sh;
          phase_d = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (!file_byte_i[7] && !rs_vld_q) begin
          phase_d = PH_ABANDON;
        end else begin
          if (st != StatusSysex && st != StatusEscape && st != StatusMeta) begin
            rs_d     = st;
            rs_vld_d = 1'b1;
          end
          if (st_explicit && st == StatusMeta) begin
            phase_d = PH_MTYPE;
          end else if (st_explicit && (st == StatusSysex || st == StatusEscape)) begin
            phase_d = PH_SXLEN;
            vacc_d  = '0;
          end else begin
            case (st[7:4])
              ChanNoteOff, ChanNoteOn, ChanPolyPress, ChanControl, ChanPitch: begin
                skip_req = 1'b1;
                skip_len = st_explicit ? 32'd2 : 32'd1;
              end
              ChanProgram, ChanPressure: begin
                skip_req = 1'b1;
                skip_len = st_explicit ? 32'd1 : 32'd0;
              end
              default: phase_d = PH_ABANDON;
            endcase
          end
        end
      end
      PH_MTYPE: begin
        meta_d = file_byte_i;
        if (file_byte_i == MetaEot) begin
          phase_d = PH_ABANDON;
        end else begin
          phase_d = PH_MLEN;
          vacc_d  = '0;
        end
      end
      PH_MLEN: begin
        vacc_d = vacc_sh;
        if (!file_byte_i[7]) begin
          if (meta_q == MetaTempo && vacc_sh == TempoLen) begin
            phase_d = PH_TEMPO;
            tacc_d  = '0;
            tseen_d = '0;
          end else begin
            skip_req = 1'b1;
            skip_len = vacc_sh;
          end
        end
      end
      PH_TEMPO: begin
        tacc_d  = {tacc_q[15:0], file_byte_i};
        tseen_d = tseen_q + 2'd1;
        if (tseen_d == 2'd3) begin
          tseen_d    = '0;
          have_tempo = (tacc_d != '0);
          phase_d    = PH_DELTA;
          vacc_d     = '0;
        end
      end
      PH_SKIP: begin
        skip_d = skip_q - 32'd1;
        if (skip_d == '0) begin
          phase_d = PH_DELTA;
          vacc_d  = '0;
        end
      end
      PH_SXLEN: begin
        vacc_d = vacc_sh;
        if (!file_byte_i[7]) begin
          skip_req = 1'b1;
          skip_len = vacc_sh;
        end
      end
      PH_ABANDON: begin
      end
      default: phase_d = PH_DONE;
    endcase

    // Enter a data skip, or go straight to the next delta when nothing to skip.
    if (skip_req) begin
      if (skip_len == '0) begin
        phase_d = PH_DELTA;
        vacc_d  = '0;
      end else begin
        skip_d  = skip_len;
        phase_d = PH_SKIP;
      end
    end

    tempo_res.kind  = KIND_TEMPO;
    tempo_res.track = track_q;
    tempo_res.tick  = tick_d;
    tempo_res.tempo = tacc_d;
    tempo_res.last  = !end_of_file_i;

    // Count down the track body; close the track when it runs out.
    if (in_track) begin
      trk_left_d = trk_left_q - 32'd1;
      if (trk_left_d == '0) begin
        if (track_d != '1) track_d = track_d + 16'd1;
        phase_d     = PH_CHUNK;
        chunk_idx_d = '0;
        tag_ok_d    = 1'b1;
      end
    end

    truncated = phase_d inside {PH_DELTA, PH_STATUS, PH_MTYPE, PH_MLEN, PH_TEMPO,
                                PH_SKIP, PH_SXLEN, PH_ABANDON};
    end_res.kind  = truncated ? KIND_END_TRUNC : KIND_END_CLEAN;
    end_res.track = track_d;
    end_res.tick  = '0;
    end_res.tempo = '0;
    end_res.last  = 1'b1;

    if (end_of_file_i) begin
      phase_d     = PH_HEADER;
      hdr_seen_d  = '0;
      chunk_idx_d = '0;
      tag_ok_d    = 1'b1;
      trk_left_d  = '0;
      tick_d      = '0;
      rs_d        = '0;
      rs_vld_d    = 1'b0;
      track_d     = '0;
      vacc_d      = '0;
      meta_d      = '0;
      skip_d      = '0;
      tacc_d      = '0;
      tseen_d     = '0;
    end

    push_o.res[1] = end_res;
    if (have_tempo) begin
      push_o.res[0] = tempo_res;
    end else begin
      push_o.res[0] = end_res;
    end
    if (!go_i) begin
      push_o.cnt = 2'd0;
    end else begin
      push_o.cnt = 2'(have_tempo) + 2'(end_of_file_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_seen_q  <= '0;
      chunk_idx_q <= '0;
      tag_ok_q    <= 1'b1;
      trk_left_q  <= '0;
      tick_q      <= '0;
      rs_q        <= '0;
      rs_vld_q    <= 1'b0;
      track_q     <= '0;
      vacc_q      <= '0;
      meta_q      <= '0;
      skip_q      <= '0;
      tacc_q      <= '0;
      tseen_q     <= '0;
    end else if (go_i) begin
      phase_q     <= phase_d;
      hdr_seen_q  <= hdr_seen_d;
      chunk_idx_q <= chunk_idx_d;
      tag_ok_q    <= tag_ok_d;
      trk_left_q  <= trk_left_d;
      tick_q      <= tick_d;
      rs_q        <= rs_d;
      rs_vld_q    <= rs_vld_d;
      track_q     <= track_d;
      vacc_q      <= vacc_d;
      meta_q      <= meta_d;
      skip_q      <= skip_d;
      tacc_q      <= tacc_d;
      tseen_q     <= tseen_d;
    end
  end

  `MTE_ASSERT(a_eof_resets, (go_i && end_of_file_i) |=> (phase_q == PH_HEADER))
  `MTE_ASSERT(a_tempo_first, (push_o.cnt == 2'd2) |-> (push_o.res[0].kind == KIND_TEMPO))
  `MTE_ASSERT_NEVER(a_running_status_meta, rs_vld_q && (rs_q == StatusMeta))

endmodule

FILE: hw/rtl/mte_result_fifo.sv
// ----------------------------------------------------------------------------
// mte_result_fifo
// Four-entry result queue, up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
`include "midi_tempo_event_extractor_top_macros.svh"

module mte_result_fifo import mte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mte_push_t   push_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output mte_result_t out_res_o
);

  mte_result_t mem_q [4];
  logic [1:0]  wr_ptr_q, wr_ptr_d;
  logic [1:0]  rd_ptr_q, rd_ptr_d;
  logic [2:0]  count_q, count_d;
  logic        pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_res_o   = mem_q[rd_ptr_q];
  // Leave space for the worst case of two results from one byte.
  assign room_o      = (count_q <= 3'd2);

  assign wr_ptr_d = wr_ptr_q + push_i.cnt;
  assign rd_ptr_d = rd_ptr_q + 2'(pop);
  assign count_d  = count_q + 3'(push_i.cnt) - 3'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.res[0];
    if (push_i.cnt == 2'd2) mem_q[wr_ptr_q + 2'd1] <= push_i.res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `MTE_ASSERT(a_push_has_room, (push_i.cnt != 2'd0) |-> (count_q <= 3'd2))
  `MTE_ASSERT(a_count_bound, count_q <= 3'd4)
  `MTE_ASSERT(a_ptr_gap, (wr_ptr_q - rd_ptr_q) == count_q[1:0])

endmodule

FILE: tb/sv/midi_tempo_event_extractor_top_tb.sv
// ----------------------------------------------------------------------------
// midi_tempo_event_extractor_top_tb
// Self-checking bench for the set-tempo extractor: feeds whole MIDI files
// (directed table, then randomly built files) and checks every result
// against a byte-level parser kept in the bench.
// ----------------------------------------------------------------------------
module midi_tempo_event_extractor_top_tb;
  import mte_pkg::*;

  localparam int RandomBytes = 1600;
  localparam int DrainCycles = 20;

  typedef struct {
    logic [7:0]  data;
    logic        eof;
    logic        typed;
    mte_result_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  file_byte_i;
  logic        end_of_file_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_kind_o;
  logic [15:0] track_number_o;
  logic [31:0] event_tick_o;
  logic [23:0] tempo_us_o;
  logic        last_result_o;

  // Side information travelling with the byte in flight: a typed-in result
  // replaces the parser's answer for that transaction.
  logic        row_typed;
  mte_result_t row_result;

  bit          in_idle;
  bit          out_idle;
  int          stall_left;
  int          fail_count;
  int          bytes_sent;
  int          bytes_taken;
  int          results_seen;
  int          tempo_seen;
  int          files_sent;

  mte_result_t results_due[$];
  mte_result_t byte_results[$];
  dir_row_t    directed_rows[$];
  logic [7:0]  track_body[$];
  logic [7:0]  file_bytes[$];

  // Parser state of the bench, updated once per accepted byte.
  mte_phase_e  ps_phase;
  logic [3:0]  hdr_cnt;
  logic [2:0]  chk_idx;
  logic        tag_ok;
  logic [31:0] trk_left;
  logic [31:0] tick_acc;
  logic [7:0]  run_stat;
  logic        run_ok;
  logic [15:0] trk_idx;
  logic [31:0] vlq;
  logic [7:0]  meta_kind;
  logic [31:0] skip_left;
  logic [23:0] tempo_acc;
  logic [1:0]  tempo_cnt;

  midi_tempo_event_extractor_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .file_byte_i    (file_byte_i),
    .end_of_file_i  (end_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .track_number_o (track_number_o),
    .event_tick_o   (event_tick_o),
    .tempo_us_o     (tempo_us_o),
    .last_result_o  (last_result_o)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #6000000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Bench parser
  // --------------------------------------------------------------------------
  task automatic clear_parser();
    ps_phase  = PH_HEADER;
    hdr_cnt   = '0;
    chk_idx   = '0;
    tag_ok    = 1'b1;
    trk_left  = '0;
    tick_acc  = '0;
    run_stat  = '0;
    run_ok    = 1'b0;
    trk_idx   = '0;
    vlq       = '0;
    meta_kind = '0;
    skip_left = '0;
    tempo_acc = '0;
    tempo_cnt = '0;
  endtask

  task automatic begin_delta();
    ps_phase = PH_DELTA;
    vlq      = '0;
  endtask

  // A zero-length skip goes straight back to the next delta time.
  task automatic begin_skip(input logic [31:0] n);
    if (n == 0) begin
      begin_delta();
    end else begin
      skip_left = n;
      ps_phase  = PH_SKIP;
    end
  endtask

  // Advance the parser by one file byte; results land in byte_results.
  task automatic parse_midi_byte(input logic [7:0] b, input logic eof);
    logic        in_trk;
    logic        got_tempo;
    logic [23:0] tval;
    logic [7:0]  stat;
    logic [31:0] ndata;
    mte_result_t r;
    in_trk    = 1'b0;
    got_tempo = 1'b0;
    tval      = '0;
    byte_results.delete();
    case (ps_phase)
      PH_HEADER: begin
        hdr_cnt++;
        if (hdr_cnt >= HdrLen) begin
          ps_phase = PH_CHUNK;
          chk_idx  = '0;
          tag_ok   = 1'b1;
        end
      end
      PH_CHUNK: begin
        // Four tag bytes, then the big-endian length.
        if (chk_idx < TagLen) begin
          if (b != TagBytes[chk_idx[1:0]]) tag_ok = 1'b0;
        end else begin
          trk_left = {trk_left[23:0], b};
        end
        if (chk_idx >= ChunkLen - 1) begin
          chk_idx = '0;
          if (!tag_ok) begin
            ps_phase = PH_DONE;
          end else if (trk_left == 0) begin
            // Empty track: counts as a track and ends at once.
            if (trk_idx != 16'hFFFF) trk_idx++;
            tag_ok = 1'b1;
          end else begin
            tick_acc = '0;
            run_ok   = 1'b0;
            run_stat = '0;
            begin_delta();
          end
        end else begin
          chk_idx++;
        end
        if (chk_idx == 0 && ps_phase == PH_CHUNK) trk_left = '0;
      end
      PH_DELTA: begin
        in_trk = 1'b1;
        vlq = {vlq[24:0], b[6:0]};
        if (!b[7]) begin
          tick_acc += vlq;
          ps_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        in_trk = 1'b1;
        if (!b[7] && !run_ok) begin
          // Data byte with no running status to fall back on.
          ps_phase = PH_ABANDON;
        end else begin
          stat = b[7] ? b : run_stat;
          if (stat != StatusSysex && stat != StatusEscape && stat != StatusMeta) begin
            run_stat = stat;
            run_ok   = 1'b1;
          end
          if (b[7] && stat == StatusMeta) begin
            ps_phase = PH_MTYPE;
          end else if (b[7] && (stat == StatusSysex || stat == StatusEscape)) begin
            ps_phase = PH_SXLEN;
            vlq      = '0;
          end else begin
            case (stat[7:4])
              ChanNoteOff, ChanNoteOn, ChanPolyPress, ChanControl, ChanPitch: ndata = 2;
              ChanProgram, ChanPressure: ndata = 1;
              default: ndata = 0;
            endcase
            if (ndata == 0) ps_phase = PH_ABANDON;
            else begin_skip(b[7] ? ndata : ndata - 1);
          end
        end
      end
      PH_MTYPE: begin
        in_trk    = 1'b1;
        meta_kind = b;
        if (b == MetaEot) begin
          ps_phase = PH_ABANDON;
        end else begin
          ps_phase = PH_MLEN;
          vlq      = '0;
        end
      end
      PH_MLEN: begin
        in_trk = 1'b1;
        vlq = {vlq[24:0], b[6:0]};
        if (!b[7]) begin
          if (meta_kind == MetaTempo && vlq == TempoLen) begin
            ps_phase  = PH_TEMPO;
            tempo_acc = '0;
            tempo_cnt = '0;
          end else begin
            begin_skip(vlq);
          end
        end
      end
      PH_TEMPO: begin
        in_trk    = 1'b1;
        tempo_acc = {tempo_acc[15:0], b};
        tempo_cnt++;
        if (tempo_cnt == 2'd3) begin
          tempo_cnt = '0;
          if (tempo_acc != 0) begin
            got_tempo = 1'b1;
            tval      = tempo_acc;
          end
          begin_delta();
        end
      end
      PH_SKIP: begin
        in_trk = 1'b1;
        skip_left--;
        if (skip_left == 0) begin_delta();
      end
      PH_SXLEN: begin
        in_trk = 1'b1;
        vlq = {vlq[24:0], b[6:0]};
        if (!b[7]) begin_skip(vlq);
      end
      PH_ABANDON: in_trk = 1'b1;
      default:    ps_phase = PH_DONE;
    endcase

    if (got_tempo) begin
      r.kind  = KIND_TEMPO;
      r.track = trk_idx;
      r.tick  = tick_acc;
      r.tempo = tval;
      r.last  = !eof;
      byte_results.insert(byte_results.size(), r);
    end

    // Every byte inside a track uses up its length, whatever the phase.
    if (in_trk) begin
      trk_left--;
      if (trk_left == 0) begin
        if (trk_idx != 16'hFFFF) trk_idx++;
        ps_phase = PH_CHUNK;
        chk_idx  = '0;
        tag_ok   = 1'b1;
      end
    end

    if (eof) begin
      r.kind  = (ps_phase != PH_HEADER && ps_phase != PH_CHUNK && ps_phase != PH_DONE) ?
                KIND_END_TRUNC : KIND_END_CLEAN;
      r.track = trk_idx;
      r.tick  = '0;
      r.tempo = '0;
      r.last  = 1'b1;
      byte_results.insert(byte_results.size(), r);
      clear_parser();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b, input logic eof);
    dir_row_t row;
    row.data  = b;
    row.eof   = eof;
    row.typed = 1'b0;
    row.res   = '0;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // End results carry zero tick and tempo, so they can be typed in directly.
  task automatic add_typed(input logic [7:0] b, input mte_kind_e kind,
                           input logic [15:0] track);
    dir_row_t row;
    row.data      = b;
    row.eof       = 1'b1;
    row.typed     = 1'b1;
    row.res       = '0;
    row.res.kind  = kind;
    row.res.track = track;
    row.res.last  = 1'b1;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic body_put(input logic [7:0] b);
    track_body.insert(track_body.size(), b);
  endtask

  task automatic file_put(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  // Minimal variable-length encoding, now and then with a redundant zero group.
  task automatic put_len(input logic [31:0] v);
    logic [31:0] rest;
    logic [7:0]  grp[$];
    rest = v;
    grp.push_front({1'b0, rest[6:0]});
    rest = rest >> 7;
    while (rest != 0) begin
      grp.push_front({1'b1, rest[6:0]});
      rest = rest >> 7;
    end
    if ($urandom_range(0, 7) == 0) grp.push_front(8'h80);
    foreach (grp[i]) body_put(grp[i]);
  endtask

  task automatic put_data(input int n);
    repeat (n) body_put(8'($urandom));
  endtask

  // Offer one byte; return once the block has taken it.
  task automatic send_item(input logic [7:0] b, input logic eof, input logic typed,
                           input mte_result_t res);
    int gap;
    gap = in_idle ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    file_byte_i   <= b;
    end_of_file_i <= eof;
    row_typed     <= typed;
    row_result    <= res;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: after each accepted result, hold stall at random, only while out_idle is set.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      int n;
      n = out_idle ? $urandom_range(0, 4) : 0;
      stall_left  <= n;
      out_stall_i <= (n != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input transactions, then check output transactions.
  // Both sides sample pre-edge values, so ordering within the step is moot.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        mte_result_t typed_res;
        typed_res = row_result;
        parse_midi_byte(file_byte_i, end_of_file_i);
        if (row_typed) results_due.insert(results_due.size(), typed_res);
        else foreach (byte_results[i]) results_due.insert(results_due.size(), byte_results[i]);
        bytes_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        mte_result_t want;
        results_seen++;
        if (result_kind_o == KIND_TEMPO) tempo_seen++;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d track %0d tick 0x%0h",
                   $time, result_kind_o, track_number_o, event_tick_o);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(result_kind_o));
          check_field("track_number", 32'(want.track), 32'(track_number_o));
          check_field("event_tick", want.tick, event_tick_o);
          check_field("tempo_us", 32'(want.tempo), 32'(tempo_us_o));
          check_field("last_result", 32'(want.last), 32'(last_result_o));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int          sel;
    int          n;
    int          nchunks;
    int          cut;
    logic [31:0] len;
    logic [7:0]  st;
    logic [23:0] us;
    bit          stop_chunks;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    file_byte_i   = '0;
    end_of_file_i = 1'b0;
    row_typed     = 1'b0;
    row_result    = '0;
    in_idle       = 1'b1;
    out_idle      = 1'b1;
    clear_parser();

    // Directed table: a one-byte file, then one short file that carries
    // the largest tempo in a track of its own.
    add_typed(8'h00, KIND_END_CLEAN, 16'd0);
    for (int i = 0; i < HdrLen; i++) add_byte(i[0] ? 8'hFF : 8'h00, 1'b0);
    for (int i = 0; i < TagLen; i++) add_byte(TagBytes[i], 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h07, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(StatusMeta, 1'b0);
    add_byte(MetaTempo, 1'b0);
    add_byte(8'h03, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0);
    // Track is complete; the file ends on the first byte of the next header.
    add_typed(TagBytes[0], KIND_END_CLEAN, 16'd1);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].data, directed_rows[i].eof, directed_rows[i].typed,
                directed_rows[i].res);

    // Random files: mostly well-formed tracks with random events, with bad
    // tags, wrong lengths and cut-off files mixed in.
    while (bytes_sent < RandomBytes) begin
      in_idle  = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      file_bytes.delete();
      repeat (HdrLen) file_put(8'($urandom));
      nchunks     = $urandom_range(0, 4);
      stop_chunks = 1'b0;
      for (int c = 0; c < nchunks && !stop_chunks; c++) begin
        if ($urandom_range(0, 9) == 0) begin
          // Bad tag: flip one bit of one tag byte, then trailing junk.
          n = $urandom_range(0, 3);
          for (int k = 0; k < TagLen; k++)
            file_put(k == n ? TagBytes[k] ^ (8'h01 << $urandom_range(0, 7)) : TagBytes[k]);
          repeat (4 + $urandom_range(0, 6)) file_put(8'($urandom));
          stop_chunks = 1'b1;
        end else begin
          track_body.delete();
          repeat ($urandom_range(0, 8)) begin
            // Delta time: usually one byte, sometimes long enough to wrap.
            sel = $urandom_range(0, 19);
            n   = (sel < 12) ? 1 : (sel < 16) ? 2 : (sel < 18) ? $urandom_range(3, 4)
                                                               : $urandom_range(5, 6);
            repeat (n - 1) body_put({1'b1, 7'($urandom)});
            body_put({1'b0, 7'($urandom)});
            case ($urandom_range(0, 15))
              0, 1, 2, 3: begin
                us = 24'($urandom);
                sel = $urandom_range(0, 7);
                if (sel == 0) us = '0;
                else if (sel == 1) us = '1;
                body_put(StatusMeta);
                body_put(MetaTempo);
                put_len(TempoLen);
                body_put(us[23:16]);
                body_put(us[15:8]);
                body_put(us[7:0]);
              end
              4: begin
                // Tempo meta with a length other than three: skipped.
                n = $urandom_range(0, 6);
                if (n == TempoLen) n++;
                body_put(StatusMeta);
                body_put(MetaTempo);
                put_len(n);
                put_data(n);
              end
              5: begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 160)
                                                : $urandom_range(0, 5);
                body_put(StatusMeta);
                body_put(8'($urandom));
                put_len(n);
                put_data(n);
              end
              6: begin
                body_put(StatusMeta);
                body_put(MetaEot);
                body_put(8'h00);
              end
              7: begin
                n = $urandom_range(0, 6);
                body_put($urandom_range(0, 1) ? StatusSysex : StatusEscape);
                put_len(n);
                put_data(n);
              end
              8, 9, 10, 11: begin
                st = 8'($urandom_range(8'h80, 8'hEF));
                body_put(st);
                n = (st[7:4] == ChanProgram || st[7:4] == ChanPressure) ? 1 : 2;
                repeat (n) body_put({1'b0, 7'($urandom)});
              end
              12, 13: begin
                // Running status data, valid or not depending on history.
                repeat ($urandom_range(1, 2)) body_put({1'b0, 7'($urandom)});
              end
              14: begin
                // Undefined system status: abandons the track.
                st = StatusSysex | 8'($urandom_range(1, 14));
                if (st == StatusEscape) st = StatusSysex | 8'h01;
                body_put(st);
              end
              default: body_put(8'($urandom));
            endcase
          end
          // Length: mostly exact, else empty, short, long or huge.
          sel = $urandom_range(0, 19);
          len = track_body.size();
          if (sel == 14 || sel == 15) len = '0;
          else if (sel == 16 || sel == 17) len = (len == 0) ? '0 : $urandom_range(0, len - 1);
          else if (sel == 18) len = len + $urandom_range(1, 4);
          else if (sel == 19) len = $urandom;
          for (int k = 0; k < TagLen; k++) file_put(TagBytes[k]);
          file_put(len[31:24]);
          file_put(len[23:16]);
          file_put(len[15:8]);
          file_put(len[7:0]);
          if (sel != 14 && sel != 15) foreach (track_body[i]) file_put(track_body[i]);
        end
      end
      // Cut some files short so the end lands in any phase.
      cut = file_bytes.size();
      if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, file_bytes.size());
      for (int i = 0; i < cut; i++)
        send_item(file_bytes[i], i == cut - 1, 1'b0, '0);
      files_sent++;
    end
    in_valid_i <= 1'b0;

    // Drain: wait for the monitor to see every byte and every result.
    out_idle = 1'b1;
    while (results_due.size() != 0 || bytes_taken != bytes_sent) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d files and %0d bytes (directed table plus random files)",
             files_sent + 2, bytes_taken);
    $display("checked %0d results, %0d of them tempo events", results_seen, tempo_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
